// File: src/rrrt_pkg.sv
// Shared widths, constants and types for the range remap rule table.
`timescale 1ns / 1ps
package rrrt_pkg;

  localparam int KEY_W = 24;
  localparam int IDX_W = 16;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One stored rule.
  typedef struct packed {
    logic [KEY_W-1:0] src_key;
    logic [KEY_W-1:0] dst_key;
    logic [IDX_W-1:0] src_first;
    logic [IDX_W-1:0] src_last;
    logic [IDX_W-1:0] dst_first;
  } rrrt_rule_t;

  // Lookup word that travels down the chain of cells.
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic             hit;
    logic [KEY_W-1:0] rkey;
    logic [IDX_W-1:0] ridx;
  } rrrt_tok_t;

endpackage

// File: src/rrrt_cell.sv
// One rule cell: holds a rule and checks the passing lookup word against it.
`timescale 1ns / 1ps
module rrrt_cell
  import rrrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  rrrt_rule_t wr_rule,
  input  logic       active,
  input  rrrt_tok_t  tok_in,
  output rrrt_tok_t  tok_out
);

  rrrt_rule_t       rule_r;
  rrrt_tok_t        tok_r;
  rrrt_tok_t        tok_nxt;
  logic             match;
  logic [IDX_W-1:0] offset;
  logic [IDX_W:0]   sum;

  always_comb begin
    match = active && tok_in.vld && !tok_in.hit &&
            (tok_in.key == rule_r.src_key) &&
            (tok_in.idx >= rule_r.src_first) &&
            (tok_in.idx <= rule_r.src_last);
    offset = tok_in.idx - rule_r.src_first;
    sum = {1'b0, rule_r.dst_first} + {1'b0, offset};
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.rkey = rule_r.dst_key;
      // A carry out of the add means the destination index ran past the top.
      tok_nxt.ridx = sum[IDX_W] ? IDX_MAX : sum[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_r <= wr_rule;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.key  <= tok_nxt.key;
    tok_r.idx  <= tok_nxt.idx;
    tok_r.hit  <= tok_nxt.hit;
    tok_r.rkey <= tok_nxt.rkey;
    tok_r.ridx <= tok_nxt.ridx;
  end

  assign tok_out = tok_r;

endmodule

// File: src/range_remap_rule_table_unit.sv
// Top level of the range remap rule table: control, rule count and output register.
// Insert: the result word is valid on the cycle after acceptance.
// Lookup: the word walks one cell per cycle through RULE_ENTRIES cells and is
// then registered in the output register; the block stays busy and takes no
// new word until the lookup word has left the last cell.
// Reset clears the rule count, the busy flag and all valid flags; rule storage
// is not cleared and no clearing pass is needed.
`timescale 1ns / 1ps
module range_remap_rule_table_unit
  import rrrt_pkg::*;
#(
  parameter int RULE_ENTRIES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_kind,
  input  logic [KEY_W-1:0] in_media_key,
  input  logic [IDX_W-1:0] in_episode_index,
  input  logic [KEY_W-1:0] in_target_key,
  input  logic [IDX_W-1:0] in_range_first,
  input  logic [IDX_W-1:0] in_range_last,
  input  logic [IDX_W-1:0] in_target_first,
  input  logic             in_also_self,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KEY_W-1:0] out_key,
  output logic [IDX_W-1:0] out_index,
  output logic             out_hit,
  output logic             out_status
);

  localparam int CNT_W = $clog2(RULE_ENTRIES + 1);
  localparam logic [CNT_W:0] ENTRIES_EXT = (CNT_W + 1)'(RULE_ENTRIES);

  logic [CNT_W-1:0] rule_count_r, rule_count_nxt;
  logic             busy_r;
  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic [IDX_W-1:0] out_index_r;
  logic             out_hit_r;
  logic             out_status_r;

  logic             acc;
  logic             acc_ins;
  logic             acc_lkp;
  logic [CNT_W:0]   need_total;
  logic             full;
  logic [CNT_W:0]   next_slot;

  rrrt_tok_t  tok [0:RULE_ENTRIES];
  rrrt_rule_t rule_main;
  rrrt_rule_t rule_self;

  // The output register must be free (or draining) before a new word starts.
  assign in_stall = busy_r || (out_valid_r && out_stall);
  assign acc      = in_valid && !in_stall;
  assign acc_ins  = acc && (in_kind == KIND_INSERT);
  assign acc_lkp  = acc && (in_kind == KIND_LOOKUP);

  assign need_total = {1'b0, rule_count_r} + (in_also_self ? (CNT_W + 1)'(2) : (CNT_W + 1)'(1));
  assign full       = need_total > ENTRIES_EXT;
  assign next_slot  = {1'b0, rule_count_r} + (CNT_W + 1)'(1);

  always_comb begin
    rule_main.src_key   = in_media_key;
    rule_main.dst_key   = in_target_key;
    rule_main.src_first = in_range_first;
    rule_main.src_last  = in_range_last;
    rule_main.dst_first = in_target_first;
    rule_self           = rule_main;
    rule_self.src_key   = in_target_key;
  end

  always_comb begin
    tok[0].vld  = acc_lkp;
    tok[0].key  = in_media_key;
    tok[0].idx  = in_episode_index;
    tok[0].hit  = 1'b0;
    tok[0].rkey = in_media_key;
    tok[0].ridx = in_episode_index;
  end

  for (genvar i = 0; i < RULE_ENTRIES; i++) begin : g_cell
    logic       wr_main;
    logic       wr_self;
    logic       cell_active;
    rrrt_rule_t cell_rule;

    assign wr_main     = acc_ins && !full && (CNT_W'(i) == rule_count_r);
    assign wr_self     = acc_ins && !full && in_also_self &&
                         ((CNT_W + 1)'(i) == next_slot);
    assign cell_active = CNT_W'(i) < rule_count_r;
    assign cell_rule   = wr_self ? rule_self : rule_main;

    rrrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_main || wr_self),
      .wr_rule (cell_rule),
      .active  (cell_active),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_comb begin
    rule_count_nxt = rule_count_r;
    if (acc_ins && !full) begin
      rule_count_nxt = need_total[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r <= '0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rule_count_r <= rule_count_nxt;
      if (acc_lkp) begin
        busy_r <= 1'b1;
      end else if (tok[RULE_ENTRIES].vld) begin
        busy_r <= 1'b0;
      end
      if (acc_ins || tok[RULE_ENTRIES].vld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_ins) begin
      out_key_r    <= '0;
      out_index_r  <= '0;
      out_hit_r    <= 1'b0;
      out_status_r <= full ? STATUS_FULL : STATUS_OK;
    end else if (tok[RULE_ENTRIES].vld) begin
      out_key_r    <= tok[RULE_ENTRIES].rkey;
      out_index_r  <= tok[RULE_ENTRIES].ridx;
      out_hit_r    <= tok[RULE_ENTRIES].hit;
      out_status_r <= STATUS_OK;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_key    = out_key_r;
  assign out_index  = out_index_r;
  assign out_hit    = out_hit_r;
  assign out_status = out_status_r;

`ifndef SYNTH
  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_ins && !full) |=> (rule_count_r != $past(rule_count_r)))
    else $error("accepted insert did not grow the rule count");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_ins && full) |=> ($stable(rule_count_r) && out_valid_r && out_status_r))
    else $error("rejected insert changed the table or lost its status");

  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok[RULE_ENTRIES].vld |-> (busy_r && !out_valid_r))
    else $error("lookup word left the chain with no lookup pending");

  a_lkp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_lkp |=> (busy_r && $stable(rule_count_r)))
    else $error("lookup did not hold the block busy");
`endif

endmodule
